// ----- rtl/srv_pkg.sv -----
// Shared widths, fixed-point constants and sideband types for the refraction pipeline.
// No dependencies; imported by every srv_* module and the top level.
`default_nettype none

package srv_pkg;

  localparam int FracBits  = 14;                 // Q2.14 vectors
  localparam int VecW      = 16;
  localparam int NumIn     = 7;
  localparam int InTdataW  = NumIn * VecW;
  localparam int OutTdataW = 3 * VecW;

  localparam int One       = 1 << FracBits;
  localparam int Half      = 1 << (FracBits - 1);  // rounding bias for >> FracBits
  localparam int HalfEsq   = 1 << (FracBits - 3);  // rounding bias for >> (FracBits-2)
  localparam int HalfEta   = 1 << (FracBits - 2);  // rounding bias for >> (FracBits-1)

  localparam int DW        = 28;                 // positive discriminant < 2^DW
  localparam int RadW      = DW + FracBits;      // radicand d * 2^F
  localparam int RootW     = RadW / 2;

  localparam int EtW       = 25;                 // round(eta * t) range
  localparam int VecMax    = 32767;
  localparam int VecMin    = -32768;

  typedef logic signed [VecW-1:0] vec_t;
  typedef logic signed [EtW-1:0]  etat_t;

  // Data that rides alongside the root computation
  typedef struct packed {
    logic             pass;
    etat_t [2:0]      etat;
    vec_t  [2:0]      nrm;
  } side_t;

endpackage

`default_nettype wire

// ----- rtl/srv_front.sv -----
// Front six stages: dot product, c^2, eta^2, discriminant and eta*(I - N c).
// Depends on srv_pkg.
`default_nettype none

module srv_front import srv_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             vld_i,
  input  vec_t             inc_i [3],
  input  vec_t             nrm_i [3],
  input  logic [VecW-1:0]  eta_i,
  output logic             vld_o,
  output logic [RadW-1:0]  rad_o,
  output side_t            side_o
);

  logic [5:0] vld_q;

  // stage 1
  logic signed [31:0] prod1_q [3];
  vec_t               inc1_q [3], nrm1_q [3];
  logic [31:0]        ee1_q;
  logic [VecW-1:0]    eta1_q;
  // stage 2
  logic signed [19:0] c2_q;
  logic [20:0]        esq2_q;
  vec_t               inc2_q [3], nrm2_q [3];
  logic [VecW-1:0]    eta2_q;
  // stage 3
  logic signed [39:0] cc3_q;
  logic signed [35:0] nc3_q [3];
  logic [20:0]        esq3_q;
  vec_t               inc3_q [3], nrm3_q [3];
  logic [VecW-1:0]    eta3_q;
  // stage 4
  logic signed [23:0] omc4_q;
  logic signed [19:0] t4_q [3];
  logic [20:0]        esq4_q;
  vec_t               nrm4_q [3];
  logic [VecW-1:0]    eta4_q;
  // stage 5
  logic signed [45:0] pe5_q;
  logic signed [37:0] et5_q [3];
  vec_t               nrm5_q [3];
  // stage 6
  logic [RadW-1:0]    rad6_q;
  side_t              side6_q;

  logic signed [33:0] dot;
  logic signed [31:0] p;
  logic signed [32:0] d;
  logic               pass;

  always_comb begin
    dot  = 34'(prod1_q[0]) + 34'(prod1_q[1]) + 34'(prod1_q[2]);
    p    = 32'((pe5_q + 46'(Half)) >>> FracBits);
    d    = 33'(One) - 33'(p);
    pass = !d[32] && (d != '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[4:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ee1_q  <= 32'(eta_i) * 32'(eta_i);
      eta1_q <= eta_i;
      c2_q   <= 20'((dot + 34'(Half)) >>> FracBits);
      esq2_q <= 21'((33'(ee1_q) + 33'(HalfEsq)) >> (FracBits - 2));
      eta2_q <= eta1_q;
      cc3_q  <= 40'(c2_q) * 40'(c2_q);
      esq3_q <= esq2_q;
      eta3_q <= eta2_q;
      omc4_q <= 24'(One) - 24'((cc3_q + 40'(Half)) >>> FracBits);
      esq4_q <= esq3_q;
      eta4_q <= eta3_q;
      pe5_q  <= 46'($signed({1'b0, esq4_q})) * 46'(omc4_q);
      rad6_q <= pass ? (RadW'(d[DW-1:0]) << FracBits) : '0;
      side6_q.pass <= pass;
      for (int i = 0; i < 3; i++) begin
        prod1_q[i] <= 32'(inc_i[i]) * 32'(nrm_i[i]);
        inc1_q[i]  <= inc_i[i];
        nrm1_q[i]  <= nrm_i[i];
        inc2_q[i]  <= inc1_q[i];
        nrm2_q[i]  <= nrm1_q[i];
        nc3_q[i]   <= 36'(nrm2_q[i]) * 36'(c2_q);
        inc3_q[i]  <= inc2_q[i];
        nrm3_q[i]  <= nrm2_q[i];
        t4_q[i]    <= 20'(inc3_q[i]) - 20'((nc3_q[i] + 36'(Half)) >>> FracBits);
        nrm4_q[i]  <= nrm3_q[i];
        et5_q[i]   <= 38'($signed({1'b0, eta4_q})) * 38'(t4_q[i]);
        nrm5_q[i]  <= nrm4_q[i];
        side6_q.etat[i] <= EtW'((et5_q[i] + 38'(HalfEta)) >>> (FracBits - 1));
        side6_q.nrm[i]  <= nrm5_q[i];
      end
    end
  end

  assign vld_o  = vld_q[5];
  assign rad_o  = rad6_q;
  assign side_o = side6_q;

endmodule

`default_nettype wire

// ----- rtl/srv_sqrt.sv -----
// Pipelined restoring integer square root, one result bit per stage, MSB first.
// Depends on srv_pkg; carries side_t alongside each stage.
`default_nettype none

module srv_sqrt import srv_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              vld_i,
  input  logic [RadW-1:0]   rad_i,
  input  side_t             side_i,
  output logic              vld_o,
  output logic [RootW-1:0]  root_o,
  output side_t             side_o
);

  logic [RootW-1:0] vld_q;
  logic [RadW-1:0]  rem_q  [RootW];
  logic [RootW-1:0] root_q [RootW];
  side_t            side_q [RootW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[RootW-2:0], vld_i};
    end
  end

  for (genvar j = 0; j < RootW; j++) begin : g_stage
    localparam int K = RootW - 1 - j;

    logic [RadW-1:0]  rem_in, trial;
    logic [RootW-1:0] root_in;
    side_t            side_in;
    logic             fits;

    if (j == 0) begin : g_first
      assign rem_in  = rad_i;
      assign root_in = '0;
      assign side_in = side_i;
    end else begin : g_next
      assign rem_in  = rem_q[j-1];
      assign root_in = root_q[j-1];
      assign side_in = side_q[j-1];
    end

    // (r + 2^K)^2 - r^2 = r * 2^(K+1) + 2^(2K)
    assign trial = (RadW'(root_in) << (K + 1)) | (RadW'(1) << (2 * K));
    assign fits  = rem_in >= trial;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j]  <= fits ? (rem_in - trial) : rem_in;
        root_q[j] <= fits ? (root_in | (RootW'(1) << K)) : root_in;
        side_q[j] <= side_in;
      end
    end
  end

  assign vld_o  = vld_q[RootW-1];
  assign root_o = root_q[RootW-1];
  assign side_o = side_q[RootW-1];

endmodule

`default_nettype wire

// ----- rtl/srv_back.sv -----
// Back two stages: N*root, final difference, saturation and reflection zeroing.
// Depends on srv_pkg.
`default_nettype none

module srv_back import srv_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              vld_i,
  input  logic [RootW-1:0]  root_i,
  input  side_t             side_i,
  output logic              vld_o,
  output vec_t              bent_o [3],
  output logic              pass_o
);

  logic [1:0]         vld_q;
  logic signed [37:0] prod_q [3];
  etat_t              etat_q [3];
  logic               passa_q;
  vec_t               bent_q [3];
  logic               pass_q;

  logic signed [25:0] v [3];
  vec_t               vsat [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      v[i] = 26'(etat_q[i]) - 26'((prod_q[i] + 38'(Half)) >>> FracBits);
      if (v[i] > 26'(VecMax)) begin
        vsat[i] = vec_t'(VecMax);
      end else if (v[i] < 26'(VecMin)) begin
        vsat[i] = vec_t'(VecMin);
      end else begin
        vsat[i] = v[i][VecW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      passa_q <= side_i.pass;
      pass_q  <= passa_q;
      for (int i = 0; i < 3; i++) begin
        prod_q[i] <= 38'($signed(side_i.nrm[i])) * 38'($signed({1'b0, root_i}));
        etat_q[i] <= $signed(side_i.etat[i]);
        bent_q[i] <= passa_q ? vsat[i] : '0;
      end
    end
  end

  assign vld_o  = vld_q[1];
  assign bent_o = bent_q;
  assign pass_o = pass_q;

endmodule

`default_nettype wire

// ----- rtl/snell_refraction_vector.sv -----
// Snell refraction of one ray per cycle: refracted direction or total-reflection flag.
// From request acceptance to result valid: 6 front stages, 21 root stages
// (one root bit each), 2 back stages. Throughput one request per cycle unless stalled.
// The whole pipe advances when the output register is empty or being taken.
// rst_ni clears all valid bits asynchronously; payload registers are not reset.
`default_nettype none

module snell_refraction_vector import srv_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // slave side: incident_x, incident_y, incident_z, surface_nx, surface_ny,
  // surface_nz, index_ratio (16 bits each, lowest bits first)
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  logic [InTdataW-1:0]  s_axis_tdata_i,
  // master side: bent_x, bent_y, bent_z (16 bits each, lowest bits first)
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  output logic [OutTdataW-1:0] m_axis_tdata_o,
  // tuser: passes_through (0 on total internal reflection, data then zero)
  output logic                 m_axis_tuser_o
);

  vec_t            inc [3];
  vec_t            nrm [3];
  logic [VecW-1:0] eta;

  logic            en;
  logic            fr_vld, sq_vld, out_vld;
  logic [RadW-1:0] fr_rad;
  side_t           fr_side, sq_side;
  logic [RootW-1:0] sq_root;
  vec_t            bent [3];
  logic            pass;

  // Global pipe enable: a stall only holds when the final result is unclaimed.
  assign en              = !out_vld || m_axis_tready_i;
  assign s_axis_tready_o = en;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      inc[i] = s_axis_tdata_i[VecW*i +: VecW];
      nrm[i] = s_axis_tdata_i[VecW*(i+3) +: VecW];
    end
    eta = s_axis_tdata_i[VecW*6 +: VecW];
  end

  // c = I.N, eta^2, discriminant, eta*(I - N c)
  srv_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (s_axis_tvalid_i),
    .inc_i  (inc),
    .nrm_i  (nrm),
    .eta_i  (eta),
    .vld_o  (fr_vld),
    .rad_o  (fr_rad),
    .side_o (fr_side)
  );

  // floor(sqrt(d * 2^F)); zero radicand on reflection, result ignored then
  srv_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (fr_vld),
    .rad_i  (fr_rad),
    .side_i (fr_side),
    .vld_o  (sq_vld),
    .root_o (sq_root),
    .side_o (sq_side)
  );

  // eta*(I - N c) - N*root, saturated, last stage is the output register
  srv_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (sq_vld),
    .root_i (sq_root),
    .side_i (sq_side),
    .vld_o  (out_vld),
    .bent_o (bent),
    .pass_o (pass)
  );

  assign m_axis_tvalid_o = out_vld;
  assign m_axis_tdata_o  = {bent[2], bent[1], bent[0]};
  assign m_axis_tuser_o  = pass;

endmodule

`default_nettype wire

// ----- rtl/srv_checker.sv -----
// Port-level checks for snell_refraction_vector, attached by bind below.
// Depends on srv_pkg and the top-level port list.
`default_nettype none

module srv_checker import srv_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 s_axis_tready_o,
  input logic                 m_axis_tvalid_o,
  input logic                 m_axis_tready_i,
  input logic [OutTdataW-1:0] m_axis_tdata_o,
  input logic                 m_axis_tuser_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("result changed while stalled");

  a_tir_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o |-> m_axis_tdata_o == '0)
    else $error("reflection result carries nonzero vector");

  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o == (!m_axis_tvalid_o || m_axis_tready_i))
    else $error("input ready disagrees with output stall");

  // valid bits are cleared asynchronously while reset is low
  a_reset: assert property (@(posedge clk_i)
    !rst_ni |=> !m_axis_tvalid_o)
    else $error("result valid during reset");

endmodule

bind snell_refraction_vector srv_checker u_srv_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);

`default_nettype wire
